@@ rtl/core/tlb_lookup_clock_replace_macros.svh @@
// Assertion macros for the TLB lookup block.
// Used by the top level; expects clk and rst in scope.
`ifndef TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH
`define TLB_LOOKUP_CLOCK_REPLACE_MACROS_SVH

// Same-cycle implication
`define TLBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TLBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tlbc_pkg.sv @@
// Shared constants and types for the TLB lookup block.
// No dependencies.
package tlbc_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int FRAME_BITS_DEF = 20;

  localparam int CFG_W  = 5;
  localparam int SLOT_W = 4;
  localparam int HIT_W  = 32;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef struct packed {
    logic upd;
    logic fill;
    logic wr;
    logic sweep;
    logic sweep_all;
  } flag_cmd_t;

endpackage

@@ rtl/core/tlbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlbc_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tlbc_flags.sv @@
// Per-slot valid, used and dirty bits with the clock-sweep update.
// Depends on tlbc_pkg.
module tlbc_flags #(
  parameter int SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tlbc_pkg::flag_cmd_t      cmd,
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  logic [$clog2(SLOTS)-1:0] last,
  output logic [SLOTS-1:0]         valid,
  output logic [SLOTS-1:0]         used,
  output logic [SLOTS-1:0]         dirty
);
  import tlbc_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [SLOTS-1:0] valid_next;
  logic [SLOTS-1:0] used_next;
  logic [SLOTS-1:0] dirty_next;

  always_comb begin
    valid_next = valid;
    used_next  = used;
    dirty_next = dirty;
    if (cmd.upd) begin
      if (cmd.sweep_all) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IDX_W'(i) <= last) begin
            used_next[i] = 1'b0;
          end
        end
      end
      if (cmd.sweep) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (IDX_W'(i) < idx) begin
            used_next[i] = 1'b0;
          end
        end
      end
      if (cmd.fill) begin
        valid_next[idx] = 1'b1;
        dirty_next[idx] = 1'b0;
      end
      if (cmd.wr) begin
        dirty_next[idx] = 1'b1;
      end
      used_next[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
      dirty <= '0;
    end else begin
      valid <= valid_next;
      used  <= used_next;
      dirty <= dirty_next;
    end
  end

endmodule

@@ rtl/core/tlb_lookup_clock_replace.sv @@
// Top level of the fully associative TLB with clock replacement.
// Depends on tlbc_pkg, tlbc_ram, tlbc_flags and the macros header.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  cfg     | cfg_wr_en, cfg_wr_data                           | in
//  in      | in_valid/in_ready, virtual_page, is_write,       | in
//          | walk_frame                                       |
//  out     | out_valid/out_ready, frame, hit, slot,           | out
//          | table_mark_dirty, hits_so_far                    |
//
// Each page compare takes a READ step and a CMP step through the page RAM read port.
// A hit ends the scan at the matching slot; a miss scans all n active slots, then fills,
// n = active slots. The block is ready for the next input in the cycle after the result is loaded.
// Reset clears all slot flags, the hit count and sets active to 16.
// A stalled result holds the sequencer in its output step; no input is taken then.
module tlb_lookup_clock_replace #(
  parameter int SLOTS      = tlbc_pkg::SLOTS_DEF,
  parameter int PAGE_BITS  = tlbc_pkg::PAGE_BITS_DEF,
  parameter int FRAME_BITS = tlbc_pkg::FRAME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [tlbc_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PAGE_BITS-1:0]         virtual_page,
  input  logic                         is_write,
  input  logic [FRAME_BITS-1:0]        walk_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [FRAME_BITS-1:0]        frame,
  output logic                         hit,
  output logic [tlbc_pkg::SLOT_W-1:0]  slot,
  output logic                         table_mark_dirty,
  output logic [tlbc_pkg::HIT_W-1:0]   hits_so_far
);
  import tlbc_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int NW    = (CFG_W > CW) ? CFG_W : CW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FILL,
    ST_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0]      active;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  wr_q;
  logic [FRAME_BITS-1:0] walk_q;
  logic [IDX_W-1:0]      idx;
  logic                  inv_found;
  logic [IDX_W-1:0]      inv_idx;
  logic                  unu_found;
  logic [IDX_W-1:0]      unu_idx;
  logic [HIT_W-1:0]      hit_total;
  logic [FRAME_BITS-1:0] res_frame;
  logic                  res_hit;
  logic [IDX_W-1:0]      res_idx;

  logic [NW-1:0]         active_ext;
  logic [NW-1:0]         live;
  logic [IDX_W-1:0]      last_idx;
  logic [PAGE_BITS-1:0]  page_rd;
  logic [FRAME_BITS-1:0] frame_rd;
  logic [SLOTS-1:0]      valid_vec;
  logic [SLOTS-1:0]      used_vec;
  logic [SLOTS-1:0]      dirty_vec;
  logic                  match;
  logic [IDX_W-1:0]      victim;
  logic                  fill_we;
  flag_cmd_t             flag_cmd;
  logic [IDX_W-1:0]      flag_idx;

  assign active_ext = NW'(active);
  assign live       = (active_ext == '0) ? NW'(1) :
                      (active_ext > NW'(SLOTS)) ? NW'(SLOTS) : active_ext;
  assign last_idx   = IDX_W'(live - NW'(1));

  assign match   = valid_vec[idx] && (page_rd == page_q);
  assign victim  = inv_found ? inv_idx : (unu_found ? unu_idx : '0);
  assign fill_we = (state == ST_FILL);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    flag_cmd = '0;
    flag_idx = idx;
    if (state == ST_CMP && match) begin
      flag_cmd.upd = 1'b1;
      flag_cmd.wr  = wr_q;
    end else if (state == ST_FILL) begin
      flag_cmd.upd       = 1'b1;
      flag_cmd.fill      = 1'b1;
      flag_cmd.wr        = wr_q;
      flag_cmd.sweep     = !inv_found && unu_found;
      flag_cmd.sweep_all = !inv_found && !unu_found;
      flag_idx           = victim;
    end
  end

  tlbc_ram #(.WIDTH(PAGE_BITS), .DEPTH(SLOTS)) u_page_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (victim),
    .wdata (page_q),
    .raddr (idx),
    .rdata (page_rd)
  );

  tlbc_ram #(.WIDTH(FRAME_BITS), .DEPTH(SLOTS)) u_frame_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (victim),
    .wdata (walk_q),
    .raddr (idx),
    .rdata (frame_rd)
  );

  tlbc_flags #(.SLOTS(SLOTS)) u_flags (
    .clk   (clk),
    .rst   (rst),
    .cmd   (flag_cmd),
    .idx   (flag_idx),
    .last  (last_idx),
    .valid (valid_vec),
    .used  (used_vec),
    .dirty (dirty_vec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= ACTIVE_RESET;
      hit_total <= '0;
      out_valid <= 1'b0;
      inv_found <= 1'b0;
      unu_found <= 1'b0;
      idx       <= '0;
    end else begin
      if (cfg_wr_en) begin
        active <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            page_q    <= virtual_page;
            wr_q      <= is_write;
            walk_q    <= walk_frame;
            idx       <= '0;
            inv_found <= 1'b0;
            unu_found <= 1'b0;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!valid_vec[idx] && !inv_found) begin
            inv_found <= 1'b1;
            inv_idx   <= idx;
          end
          if (!used_vec[idx] && !unu_found) begin
            unu_found <= 1'b1;
            unu_idx   <= idx;
          end
          if (match) begin
            res_frame <= frame_rd;
            res_hit   <= 1'b1;
            res_idx   <= idx;
            hit_total <= hit_total + HIT_W'(1);
            state     <= ST_OUT;
          end else if (idx == last_idx) begin
            state <= ST_FILL;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_READ;
          end
        end
        ST_FILL: begin
          res_frame <= walk_q;
          res_hit   <= 1'b0;
          res_idx   <= victim;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            frame            <= res_frame;
            hit              <= res_hit;
            slot             <= SLOT_W'(res_idx);
            table_mark_dirty <= wr_q;
            hits_so_far      <= hit_total;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "tlb_lookup_clock_replace_macros.svh"

  `TLBC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after input transfer")
  `TLBC_ASSERT_NOW(a_scan_bound, state == ST_CMP, idx <= last_idx, "scan index past active slots")
  `TLBC_ASSERT_NEXT(a_fill_flags, state == ST_FILL,
    valid_vec[$past(victim)] && used_vec[$past(victim)] &&
    (dirty_vec[$past(victim)] == $past(wr_q)), "filled slot flags wrong")

endmodule

@@ tb/tlb_xlate_checker.sv @@
// Checker for the clock-replacement TLB: tracks slot state, predicts each translation.
// Watches the config, input and result channels; depends on tlbc_pkg only.
module tlb_xlate_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [tlbc_pkg::CFG_W-1:0]            cfg_wr_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [tlbc_pkg::PAGE_BITS_DEF-1:0]    virtual_page,
  input  logic                                  is_write,
  input  logic [tlbc_pkg::FRAME_BITS_DEF-1:0]   walk_frame,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [tlbc_pkg::FRAME_BITS_DEF-1:0]   frame,
  input  logic                                  hit,
  input  logic [tlbc_pkg::SLOT_W-1:0]           slot,
  input  logic                                  table_mark_dirty,
  input  logic [tlbc_pkg::HIT_W-1:0]            hits_so_far,
  output int                                    mismatches,
  output int                                    expected_left
);

  localparam int NSLOT = tlbc_pkg::SLOTS_DEF;
  localparam int PB    = tlbc_pkg::PAGE_BITS_DEF;
  localparam int FB    = tlbc_pkg::FRAME_BITS_DEF;

  typedef struct packed {
    logic [FB-1:0]               frame;
    logic                        hit;
    logic [tlbc_pkg::SLOT_W-1:0] slot;
    logic                        mark_dirty;
    logic [tlbc_pkg::HIT_W-1:0]  hits;
  } xlate_t;

  bit                          tag_valid [NSLOT];
  bit                          tag_used  [NSLOT];
  bit                          tag_dirty [NSLOT];
  logic [PB-1:0]               tag_page  [NSLOT];
  logic [FB-1:0]               tag_frame [NSLOT];
  bit [tlbc_pkg::HIT_W-1:0]    hit_count;
  bit [tlbc_pkg::CFG_W-1:0]    live_cfg;
  xlate_t                      xlate_due [$];
  xlate_t                      xlate_head;

  function automatic xlate_t translate_page(input logic [PB-1:0] page, input logic wr,
                                            input logic [FB-1:0] walk);
    int     n;
    int     s;
    bit     found;
    xlate_t r;
    n = (live_cfg == 0) ? 1 : ((live_cfg > NSLOT) ? NSLOT : int'(live_cfg));
    found = 1'b0;
    s = -1;
    for (int i = 0; i < n; i++)
      if (!found && tag_valid[i] && tag_page[i] == page) begin
        s = i;
        found = 1'b1;
      end
    if (found) begin
      hit_count = hit_count + 1;
      r.frame = tag_frame[s];
    end else begin
      r.frame = walk;
      for (int i = 0; i < n; i++)
        if (s < 0 && !tag_valid[i]) s = i;
      if (s < 0) begin
        // sweep: clear used bits until the first clear one
        for (int i = 0; i < n; i++)
          if (s < 0) begin
            if (!tag_used[i]) s = i;
            else tag_used[i] = 1'b0;
          end
        if (s < 0) s = 0;
      end
      tag_valid[s] = 1'b1;
      tag_page[s]  = page;
      tag_frame[s] = walk;
      tag_dirty[s] = 1'b0;
    end
    if (wr) tag_dirty[s] = 1'b1;
    tag_used[s]  = 1'b1;
    r.hit        = found;
    r.slot       = s[tlbc_pkg::SLOT_W-1:0];
    r.mark_dirty = wr;
    r.hits       = hit_count;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30)
      $display("mismatch on %s: got %0h, want %0h", field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        tag_valid[i] = 1'b0;
        tag_used[i]  = 1'b0;
        tag_dirty[i] = 1'b0;
      end
      hit_count = '0;
      live_cfg = tlbc_pkg::ACTIVE_RESET;
      xlate_due.delete();
      mismatches = 0;
      expected_left = 0;
    end else begin
      if (cfg_wr_en) live_cfg = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (xlate_due.size() == 0) begin
          report_mismatch("result with none pending", 32'(frame), 32'd0);
        end else begin
          xlate_head = xlate_due.pop_front();
          if (frame !== xlate_head.frame)
            report_mismatch("frame", 32'(frame), 32'(xlate_head.frame));
          if (hit !== xlate_head.hit)
            report_mismatch("hit", 32'(hit), 32'(xlate_head.hit));
          if (slot !== xlate_head.slot)
            report_mismatch("slot", 32'(slot), 32'(xlate_head.slot));
          if (table_mark_dirty !== xlate_head.mark_dirty)
            report_mismatch("table_mark_dirty", 32'(table_mark_dirty),
                            32'(xlate_head.mark_dirty));
          if (hits_so_far !== xlate_head.hits)
            report_mismatch("hits_so_far", hits_so_far, xlate_head.hits);
        end
      end
      if (in_valid && in_ready)
        xlate_due.push_back(translate_page(virtual_page, is_write, walk_frame));
      expected_left = xlate_due.size();
    end
  end

endmodule

@@ tb/tb_tlb_lookup_clock_replace.sv @@
// Testbench top for the clock-replacement TLB: clock, reset, stimulus and verdict.
// Depends on tlbc_pkg, the RTL top tlb_lookup_clock_replace and tlb_xlate_checker.
module tb_tlb_lookup_clock_replace;

  localparam int PB = tlbc_pkg::PAGE_BITS_DEF;
  localparam int FB = tlbc_pkg::FRAME_BITS_DEF;
  localparam int POOL = 24;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_wr_en = 1'b0;
  logic [tlbc_pkg::CFG_W-1:0]        cfg_wr_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [PB-1:0]                     virtual_page = '0;
  logic                              is_write = 1'b0;
  logic [FB-1:0]                     walk_frame = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [FB-1:0]                     frame;
  logic                              hit;
  logic [tlbc_pkg::SLOT_W-1:0]       slot;
  logic                              table_mark_dirty;
  logic [tlbc_pkg::HIT_W-1:0]        hits_so_far;

  int mismatches;
  int expected_left;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  logic [PB-1:0]                page_pool [POOL];
  logic [tlbc_pkg::CFG_W-1:0]   phase_cfg [10];

  tlb_lookup_clock_replace dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .virtual_page(virtual_page), .is_write(is_write), .walk_frame(walk_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame(frame), .hit(hit), .slot(slot),
    .table_mark_dirty(table_mark_dirty), .hits_so_far(hits_so_far)
  );

  tlb_xlate_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .virtual_page(virtual_page), .is_write(is_write), .walk_frame(walk_frame),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame(frame), .hit(hit), .slot(slot),
    .table_mark_dirty(table_mark_dirty), .hits_so_far(hits_so_far),
    .mismatches(mismatches), .expected_left(expected_left)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_access(input logic [PB-1:0] page, input logic wr,
                             input logic [FB-1:0] walk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    virtual_page <= page;
    is_write <= wr;
    walk_frame <= walk;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic set_active(input logic [tlbc_pkg::CFG_W-1:0] count);
    drain_results();
    repeat (40) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int            live;
    int            span;
    int            r;
    logic [PB-1:0] page;
    logic [FB-1:0] walk;

    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL; i++) page_pool[i] = PB'($urandom);
    phase_cfg = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8,
                  5'($urandom_range(16, 1)), 5'd16, 5'd3};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_access(20'h00000, 1'b0, 20'h00000);
    send_access(20'hFFFFF, 1'b1, 20'hFFFFF);
    send_access(20'h00000, 1'b1, 20'h5A5A5);
    send_access(20'hFFFFF, 1'b0, 20'h00000);
    send_access(20'hAAAAA, 1'b0, 20'h55555);
    send_access(20'h55555, 1'b1, 20'hAAAAA);
    set_active(5'd3);
    send_access(20'h12345, 1'b0, 20'h11111);
    send_access(20'h23456, 1'b1, 20'h22222);
    send_access(20'hFFFFF, 1'b0, 20'h33333);
    send_access(20'h34567, 1'b0, 20'h44444);
    send_access(20'h23456, 1'b0, 20'h55555);
    send_access(20'h45678, 1'b1, 20'h66666);
    set_active(5'd1);
    send_access(20'h56789, 1'b1, 20'h77777);
    send_access(20'h56789, 1'b0, 20'h88888);
    send_access(20'h6789A, 1'b0, 20'h99999);
    set_active(5'd16);
    send_access(20'hAAAAA, 1'b1, 20'h00000);
    send_access(20'h55555, 1'b0, 20'h00000);
    send_access(20'h789AB, 1'b1, 20'hFFFFF);
    send_access(20'h6789A, 1'b0, 20'h12121);

    for (int ph = 0; ph < 10; ph++) begin
      set_active(phase_cfg[ph]);
      if (ph < 4) begin
        send_idle = 7;
        recv_idle = 74;
      end else if (ph < 7) begin
        send_idle = 74;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      live = (phase_cfg[ph] == 0) ? 1 : ((phase_cfg[ph] > 16) ? 16 : int'(phase_cfg[ph]));
      span = (live + 3 > POOL) ? POOL : live + 3;
      for (int k = 0; k < 130; k++) begin
        if (ph == 0 && k == 40) hold_req <= hold_req + 1;
        if (ph == 5 && k == 65) drain_results();
        page = ($urandom_range(99) < 85) ? page_pool[$urandom_range(span - 1)] : PB'($urandom);
        r = $urandom_range(19);
        walk = (r == 0) ? '0 : ((r == 1) ? '1 : FB'($urandom));
        send_access(page, 1'($urandom), walk);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_left == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
